// ----- rtl/mbds_pkg.sv -----
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter package
// Shared widths, result codes, register indexes and structs for the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbds_pkg;

   // Default depth of the pending byte window.
   localparam int MAX_DELIM_DEFAULT = 8;

   // Field widths.
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int DELIM_W     = 64;
   localparam int DELIM_LEN_W = 4;
   localparam int CSR_IDX_W   = 1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_BYTE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIECE_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EOS       = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DELIM_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DELIM_LENGTH = 1'b1;

   // Delimiter setup as seen by the window logic; the length is already
   // clamped to the supported range.
   typedef struct packed {
      logic [DELIM_W-1:0]     delim_bytes;
      logic [DELIM_LEN_W-1:0] delim_len;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] byte_out;
      logic              run_last;
   } rsp_item_type;

endpackage : mbds_pkg

`default_nettype wire

// ----- rtl/mbds_if.sv -----
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter channel interfaces
// Valid/ready channels for input bytes, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Input byte channel.
interface mbds_req_if;
   logic                          valid;
   logic                          ready;
   logic [mbds_pkg::BYTE_W-1:0]   byte_in;
   logic                          final_byte;

   modport source (output valid, output byte_in, output final_byte, input ready);
   modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface : mbds_req_if

// Result item channel.
interface mbds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mbds_pkg::KIND_W-1:0]   kind;
   logic [mbds_pkg::BYTE_W-1:0]   byte_out;
   logic                          run_last;

   modport source (output valid, output kind, output byte_out, output run_last,
                   input ready);
   modport sink   (input valid, input kind, input byte_out, input run_last,
                   output ready);
endinterface : mbds_rsp_if

// Register write channel.
interface mbds_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mbds_pkg::CSR_IDX_W-1:0]   reg_index;
   logic [mbds_pkg::DELIM_W-1:0]     write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface : mbds_csr_if

`default_nettype wire

// ----- rtl/multibyte_delimiter_splitter.sv -----
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter
// Splits a byte stream into pieces at a configured 1 to 8 byte delimiter (at most MAX_DELIM bytes).
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on req_if (byte_in, final_byte); a transfer takes place when
//   valid and ready are both high. Results leave on rsp_if as kind/byte_out/
//   run_last items: piece bytes, piece ends and an end-of-string marker.
//   The delimiter is set through csr_if: index 0 writes the delimiter bytes
//   (first byte in bits 7..0), index 1 writes its length. csr_if is always
//   ready; write it only while no string is in flight.
//   An input transfer passes through the input register and then the result
//   register before its first result can be transferred.
//   Throughput is one byte per cycle while rsp_if takes results and no
//   flush runs. An input marked final_byte is followed by up to N + 2
//   extra results: one per byte still pending in the window (N, at most
//   MAX_DELIM - 1), a piece end when a piece is open, and the end-of-string
//   marker. The flush sequencer holds off new input meanwhile.
//   Reset clears the window, the piece state and the registers (delimiter
//   bytes zero, length one). When rsp_if stalls, the result register holds
//   and one further input still lands in the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multibyte_delimiter_splitter #(
   parameter int MAX_DELIM = mbds_pkg::MAX_DELIM_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   mbds_req_if.sink   req_if,
   mbds_rsp_if.source rsp_if,
   mbds_csr_if.sink   csr_if
);

   mbds_pkg::cfg_type      cfg;
   mbds_pkg::rsp_item_type res;
   mbds_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                          in_valid_ff, in_valid_in;
   logic [mbds_pkg::BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic                          in_final_ff, in_final_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          item_take, res_load, out_free, req_fire;

   // Register block.
   mbds_csr #(.MAX_DELIM(MAX_DELIM)) u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // Input register: refills in the same cycle its item moves on.
   assign req_if.ready = !in_valid_ff || item_take;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.byte_in;
         in_final_in = req_if.final_byte;
      end else if (item_take) begin
         in_valid_in = 1'b0;
      end
   end

   // Window, compare and flush logic.
   mbds_window #(.MAX_DELIM(MAX_DELIM)) u_window (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (in_valid_ff),
      .item_byte  (in_byte_ff),
      .item_final (in_final_ff),
      .out_free   (out_free),
      .item_take  (item_take),
      .res_load   (res_load),
      .res        (res)
   );

   // Result register: loads when empty or when its item is taken.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.kind     = rsp_item_ff.kind;
   assign rsp_if.byte_out = rsp_item_ff.byte_out;
   assign rsp_if.run_last = rsp_item_ff.run_last;

endmodule : multibyte_delimiter_splitter

`default_nettype wire

// ----- rtl/mbds_csr.sv -----
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter registers
// Holds the delimiter bytes and length and clamps the length to 1..limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbds_csr #(
   parameter int MAX_DELIM = mbds_pkg::MAX_DELIM_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mbds_csr_if.sink         csr_if,
   output mbds_pkg::cfg_type cfg
);

   // Longest delimiter the window can compare.
   localparam int LIM = (MAX_DELIM < 8) ? MAX_DELIM : 8;
   localparam logic [mbds_pkg::DELIM_LEN_W-1:0] LIM_LEN = mbds_pkg::DELIM_LEN_W'(LIM);

   logic [mbds_pkg::DELIM_W-1:0]     delim_bytes_ff, delim_bytes_in;
   logic [mbds_pkg::DELIM_LEN_W-1:0] delim_len_ff, delim_len_in;

   // Writes are always taken.
   assign csr_if.ready = 1'b1;

   // Register write decode.
   always_comb begin
      delim_bytes_in = delim_bytes_ff;
      delim_len_in   = delim_len_ff;
      if (csr_if.valid) begin
         case (csr_if.reg_index)
            mbds_pkg::CSR_IDX_DELIM_BYTES:  delim_bytes_in = csr_if.write_data;
            mbds_pkg::CSR_IDX_DELIM_LENGTH:
               delim_len_in = csr_if.write_data[mbds_pkg::DELIM_LEN_W-1:0];
            default: begin
               delim_bytes_in = delim_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff <= '0;
         delim_len_ff   <= mbds_pkg::DELIM_LEN_W'(1);
      end else begin
         delim_bytes_ff <= delim_bytes_in;
         delim_len_ff   <= delim_len_in;
      end
   end

   // A length of zero acts as one; lengths past the limit saturate.
   always_comb begin
      cfg.delim_bytes = delim_bytes_ff;
      if (delim_len_ff == '0) begin
         cfg.delim_len = mbds_pkg::DELIM_LEN_W'(1);
      end else if (delim_len_ff > LIM_LEN) begin
         cfg.delim_len = LIM_LEN;
      end else begin
         cfg.delim_len = delim_len_ff;
      end
   end

endmodule : mbds_csr

`default_nettype wire

// ----- rtl/mbds_window.sv -----
// ----------------------------------------------------------------------------
// Multibyte delimiter splitter window
// Pending byte window, delimiter compare and end-of-string flush sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbds_window #(
   parameter int MAX_DELIM = mbds_pkg::MAX_DELIM_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mbds_pkg::cfg_type           cfg,
   input  wire logic                        item_valid,
   input  wire logic [mbds_pkg::BYTE_W-1:0] item_byte,
   input  wire logic                        item_final,
   input  wire logic                        out_free,
   output logic                             item_take,
   output logic                             res_load,
   output mbds_pkg::rsp_item_type           res
);

   localparam int LIM  = (MAX_DELIM < 8) ? MAX_DELIM : 8;
   localparam int WINW = MAX_DELIM * mbds_pkg::BYTE_W;
   localparam int CNTW = $clog2(MAX_DELIM + 1);

   // Window bytes: byte i sits at bits 8i+7..8i, index 0 is the oldest.
   // Bytes at or past the count are kept at zero.
   logic [WINW-1:0] win_ff, win_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            open_ff, open_in;
   logic            flush_ff, flush_in;

   logic [WINW-1:0]                  app_vec, step_vec;
   logic [CNTW-1:0]                  app_cnt, step_cnt;
   logic                             full, match;
   logic [mbds_pkg::DELIM_LEN_W-1:0] sh;

   // Append the incoming byte behind the pending ones.
   assign app_vec = win_ff | (WINW'(item_byte) << {cnt_ff, 3'b000});
   assign app_cnt = cnt_ff + CNTW'(1);
   assign full    = 32'(app_cnt) >= 32'(cfg.delim_len);

   // Compare the oldest bytes with the delimiter, all lanes in parallel.
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < LIM; i++) begin
         if ((mbds_pkg::DELIM_LEN_W'(i) < cfg.delim_len) &&
             (app_vec[8*i +: 8] != cfg.delim_bytes[8*i +: 8])) begin
            match = 1'b0;
         end
      end
   end

   // Drop none until full, then a matched delimiter, else the byte sent.
   always_comb begin
      if (!full) begin
         sh = '0;
      end else if (match) begin
         sh = cfg.delim_len;
      end else begin
         sh = mbds_pkg::DELIM_LEN_W'(1);
      end
   end

   assign step_vec = app_vec >> {sh, 3'b000};
   assign step_cnt = app_cnt - CNTW'(sh);

   // A new item is taken when no flush runs and the result slot is free.
   assign item_take = item_valid && !flush_ff && out_free;

   // Next state and the result to load.
   always_comb begin
      win_in       = win_ff;
      cnt_in       = cnt_ff;
      open_in      = open_ff;
      flush_in     = flush_ff;
      res_load     = 1'b0;
      res.kind     = mbds_pkg::KIND_BYTE;
      res.byte_out = '0;
      res.run_last = 1'b0;
      if (flush_ff && out_free) begin
         // Flush: pending bytes, then the piece end, then end of string.
         res_load = 1'b1;
         if (cnt_ff != '0) begin
            res.byte_out = win_ff[7:0];
            win_in       = win_ff >> mbds_pkg::BYTE_W;
            cnt_in       = cnt_ff - CNTW'(1);
            open_in      = 1'b1;
         end else if (open_ff) begin
            res.kind = mbds_pkg::KIND_PIECE_END;
            open_in  = 1'b0;
         end else begin
            res.kind     = mbds_pkg::KIND_EOS;
            res.run_last = 1'b1;
            flush_in     = 1'b0;
         end
      end else if (item_take) begin
         win_in       = step_vec;
         cnt_in       = step_cnt;
         flush_in     = item_final;
         res.run_last = !item_final;
         if (full && !match) begin
            res_load     = 1'b1;
            res.byte_out = app_vec[7:0];
            open_in      = 1'b1;
         end else if (full && open_ff) begin
            res_load = 1'b1;
            res.kind = mbds_pkg::KIND_PIECE_END;
            open_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         cnt_ff   <= '0;
         open_ff  <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         cnt_ff   <= cnt_in;
         open_ff  <= open_in;
         flush_ff <= flush_in;
      end
   end

   // The window never fills up between items.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNTW'(MAX_DELIM))
      else $error("pending window count reached its depth");

   // A finished flush leaves an empty window and no open piece.
   assert property (@(posedge clock) disable iff (reset)
      $fell(flush_ff) |-> (cnt_ff == '0 && !open_ff))
      else $error("flush ended with state left over");

   // Sending a piece byte opens the piece.
   assert property (@(posedge clock) disable iff (reset)
      (res_load && res.kind == mbds_pkg::KIND_BYTE) |=> open_ff)
      else $error("piece byte sent without opening the piece");

endmodule : mbds_window

`default_nettype wire
